>>> rtl/core/arinc429_word_codec_top_defines.svh
// ----------------------------------------------------------------------------
// ARINC 429 word codec assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ARINC429_WORD_CODEC_TOP_DEFINES_SVH
`define ARINC429_WORD_CODEC_TOP_DEFINES_SVH

`ifndef SYNTH
`define A429_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
`define A429_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: reset check failed");
`else
`define A429_ASSERT(lbl, prop)
`define A429_ASSERT_RST(lbl, prop)
`endif

`endif

>>> rtl/core/a429c_pkg.sv
// ----------------------------------------------------------------------------
// ARINC 429 word codec package
// Word layout constants, format codes and the BCD pack/unpack functions.
// ----------------------------------------------------------------------------
package a429c_pkg;

  typedef enum logic [1:0] {
    FMT_RAW = 2'd0,
    FMT_BNR = 2'd1,
    FMT_BCD = 2'd2
  } fmt_t;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_PARSE = 1'b1;

  localparam int FIELD_W = 19;
  localparam int VALUE_W = 20;
  localparam int WORD_W  = 32;
  localparam int DIGITS  = 5;
  localparam int PROD_W  = 39;

  // x / 10^(k+1) == (x * RECIP[k]) >> SHIFT[k], exact for x < 2^19
  localparam int BCD_SHIFT [DIGITS] = '{23, 26, 29, 33, 36};
  localparam logic [19:0] BCD_RECIP [DIGITS] = '{
    20'(((64'd1 << 23) + 64'd9)     / 64'd10),
    20'(((64'd1 << 26) + 64'd99)    / 64'd100),
    20'(((64'd1 << 29) + 64'd999)   / 64'd1000),
    20'(((64'd1 << 33) + 64'd9999)  / 64'd10000),
    20'(((64'd1 << 36) + 64'd99999) / 64'd100000)
  };

  function automatic logic [FIELD_W-1:0] bcd_pack(input logic [VALUE_W-1:0] v20);
    logic [FIELD_W-1:0]   q [DIGITS+1];
    logic [PROD_W-1:0]    prod;
    logic [4*DIGITS-1:0]  digits;
    q[0] = v20[FIELD_W-1:0];
    for (int k = 0; k < DIGITS; k++) begin
      prod     = PROD_W'(q[0]) * PROD_W'(BCD_RECIP[k]);
      q[k+1]   = FIELD_W'(prod >> BCD_SHIFT[k]);
    end
    for (int k = 0; k < DIGITS; k++) begin
      digits[4*k +: 4] = 4'(q[k] - FIELD_W'(q[k+1] * FIELD_W'(10)));
    end
    if (v20[VALUE_W-1] || (v20 == '0)) begin
      return '0;
    end
    return digits[FIELD_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] bcd_unpack(input logic [FIELD_W-1:0] f);
    return VALUE_W'(f[3:0])
         + VALUE_W'(f[7:4])   * VALUE_W'(10)
         + VALUE_W'(f[11:8])  * VALUE_W'(100)
         + VALUE_W'(f[15:12]) * VALUE_W'(1000)
         + VALUE_W'(f[18:16]) * VALUE_W'(10000);
  endfunction

endpackage

>>> rtl/core/arinc429_word_codec_top.sv
// ARINC 429 word codec.
// Slave stream in_*: one request per handshake builds a word from label,
// SDI, SSM and a value (raw, BNR or BCD), or parses a received 32-bit word.
// Master stream out_*: one result per request with the word, its fields,
// the value decoded per format and an odd-parity flag.
// A request accepted into the input register moves on to the result register
// (which drives out_tvalid) when that register is empty or its result is taken.
// Throughput: one request per cycle while out_tready stays high, set by the
// single pass of encode/decode logic between the two registers.
// When out_tready is low the result holds; the input register still takes
// one more request, then in_tready drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers.
// ----------------------------------------------------------------------------
// ARINC 429 word codec top level
// Two-register stream pipeline around the word build/parse logic.
// ----------------------------------------------------------------------------
`include "arinc429_word_codec_top_defines.svh"

module arinc429_word_codec_top
  import a429c_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] label_in, [9:8] sdi_in, [11:10] ssm_in, [31:12] value_in, [63:32] raw_word
  input  logic [63:0] in_tdata,
  // [0] operation, [2:1] data_format
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] word_out, [39:32] label_out, [41:40] sdi_out, [43:42] ssm_out,
  // [62:44] data_field, [82:63] value_out, [83] parity_ok, [87:84] zero
  output logic [87:0] out_tdata
);

  logic                a_valid_r;
  logic                a_op_r;
  logic [1:0]          a_fmt_r;
  logic [7:0]          a_label_r;
  logic [1:0]          a_sdi_r;
  logic [1:0]          a_ssm_r;
  logic [VALUE_W-1:0]  a_value_r;
  logic [WORD_W-1:0]   a_raw_r;

  logic                out_valid_r;
  logic                out_op_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [FIELD_W-1:0]  out_field_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic                out_parity_r;

  logic                adv;
  logic [FIELD_W-1:0]  enc_field;
  logic [WORD_W-2:0]   low31;
  logic [WORD_W-1:0]   word_nxt;
  logic [FIELD_W-1:0]  field_nxt;
  logic [VALUE_W-1:0]  value_nxt;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !a_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        a_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_op_r    <= in_tuser[0];
      a_fmt_r   <= in_tuser[2:1];
      a_label_r <= in_tdata[7:0];
      a_sdi_r   <= in_tdata[9:8];
      a_ssm_r   <= in_tdata[11:10];
      a_value_r <= in_tdata[31:12];
      a_raw_r   <= in_tdata[63:32];
    end
  end

  always_comb begin
    if (a_fmt_r == FMT_BCD) begin
      enc_field = bcd_pack(a_value_r);
    end else begin
      enc_field = a_value_r[FIELD_W-1:0];
    end
    low31 = {a_ssm_r, enc_field, a_sdi_r, a_label_r};
    if (a_op_r == OP_PARSE) begin
      word_nxt = a_raw_r;
    end else begin
      word_nxt = {~^low31, low31};
    end
    field_nxt = word_nxt[28:10];
    case (fmt_t'(a_fmt_r))
      FMT_BNR: value_nxt = {field_nxt[FIELD_W-1], field_nxt};
      FMT_BCD: value_nxt = bcd_unpack(field_nxt);
      default: value_nxt = {1'b0, field_nxt};
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid_r) begin
      out_op_r     <= a_op_r;
      out_word_r   <= word_nxt;
      out_field_r  <= field_nxt;
      out_value_r  <= value_nxt;
      out_parity_r <= ^word_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_parity_r, out_value_r, out_field_r,
                       out_word_r[30:29], out_word_r[9:8], out_word_r[7:0],
                       out_word_r};

  `A429_ASSERT(a_build_odd, out_valid_r && (out_op_r == OP_BUILD) |-> (^out_word_r))
  `A429_ASSERT(a_field_sync, out_valid_r |-> (out_field_r == out_word_r[28:10]))
  `A429_ASSERT(a_full_stall, a_valid_r && out_valid_r && !out_tready |-> !in_tready)
  `A429_ASSERT(a_stage_move, a_valid_r && adv |=> out_valid_r)
  `A429_ASSERT_RST(a_rst_clear, !rst_n |=> !out_tvalid)

endmodule
